### src/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg - shared types and constants of the sorted interval table
// Table geometry, word layouts, op and status codes, controller handshake.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int TIME_BITS   = 24;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int OP_W     = 4;
  localparam int STAT_W   = 3;
  localparam int ID_W     = 32;
  localparam int COLOUR_W = 32;
  localparam int IX_W     = 6;
  localparam int COUNT_W  = 7;

  localparam logic [TIME_BITS-1:0] TIME_TOP = {TIME_BITS{1'b1}};
  localparam logic [ID_W-1:0]      ID_NULL  = '0;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 4'd0,
    OP_SET_START  = 4'd1,
    OP_SET_END    = 4'd2,
    OP_DELETE     = 4'd3,
    OP_FIND       = 4'd4,
    OP_GAP_AHEAD  = 4'd5,
    OP_GAP_BEHIND = 4'd6,
    OP_CHAIN      = 4'd7,
    OP_READ_ID    = 4'd8,
    OP_READ_INDEX = 4'd9,
    OP_TOTAL      = 4'd10
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_REJECT = 3'd1,
    ST_NO_ID  = 3'd2,
    ST_FULL   = 3'd3,
    ST_NONE   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_UPDATE,
    ACT_DELETE
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_DECIDE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_WRITE,
    S_FINISH
  } fsm_t;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [COLOUR_W-1:0]  colour;
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS-1:0] length;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [TIME_BITS-1:0] at_time;
    logic [TIME_BITS-1:0] span_length;
    logic [COLOUR_W-1:0]  rgba_colour;
    logic [ID_W-1:0]      entry_id;
    logic [IX_W-1:0]      entry_index;
  } cmd_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [ID_W-1:0]      result_id;
    logic [TIME_BITS-1:0] result_start;
    logic [TIME_BITS-1:0] result_length;
    logic [COLOUR_W-1:0]  result_colour;
    logic [TIME_BITS-1:0] measure;
    logic [COUNT_W-1:0]   entry_count;
  } rsp_word_t;

  typedef struct packed {
    logic start;
    logic scan_rd;
    logic scan_ev;
    logic decide;
    logic up_rd;
    logic up_wr;
    logic dn_rd;
    logic dn_wr;
    logic wr_new;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
    act_t act;
    logic ins_shift;
    logic del_shift;
    logic up_more;
    logic dn_more;
    logic out_free;
  } ctl_sts_t;

endpackage

### src/sit_cmd_if.sv
// ----------------------------------------------------------------------------
// sit_cmd_if - command channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface sit_cmd_if import sit_pkg::*; ;
  logic      valid;
  logic      ready;
  cmd_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/sit_rsp_if.sv
// ----------------------------------------------------------------------------
// sit_rsp_if - response channel
// Valid/ready channel carrying one response word.
// ----------------------------------------------------------------------------
interface sit_rsp_if import sit_pkg::*; ;
  logic      valid;
  logic      ready;
  rsp_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/sorted_interval_table.sv
// ----------------------------------------------------------------------------
// sorted_interval_table - sorted table of non-overlapping intervals
//
//   channel  dir  handshake      word
//   cmd      in   valid/ready    op, at_time, span_length, rgba_colour,
//                                entry_id, entry_index
//   rsp      out  valid/ready    status, result_id/start/length/colour,
//                                measure, entry_count
//   cfg      in   cfg_we         timeline_limit (cfg_wdata)
//
// A word first scans the N held entries: each RAM entry is read through the
// registered read port (S_SCAN_RD) and then evaluated (S_SCAN_EV). Insert and
// delete shift entries (read, then write); insert and update write the result.
// Reset is synchronous and needs no clearing pass; the table starts empty.
// A stalled response holds in the output register while the next command is
// taken and scanned.
// ----------------------------------------------------------------------------
module sorted_interval_table import sit_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  sit_cmd_if.sink              cmd,
  sit_rsp_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [TIME_BITS-1:0] cfg_wdata
);

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  sit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .sts      (sts),
    .cmd      (ctl)
  );

  sit_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl),
    .sts       (sts),
    .in_word   (cmd.data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .out_word  (rsp.data)
  );

endmodule

### src/sit_ram.sv
// ----------------------------------------------------------------------------
// sit_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/sit_ctrl.sv
// ----------------------------------------------------------------------------
// sit_ctrl - sequencer of the interval table
// Steps scan, decision, shift, write-back and response load.
// ----------------------------------------------------------------------------
module sit_ctrl import sit_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  fsm_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = sts.cnt_zero ? S_DECIDE : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.scan_ev = 1'b1;
        state_next  = sts.scan_last ? S_DECIDE : S_SCAN_RD;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        case (sts.act)
          ACT_INSERT: state_next = sts.ins_shift ? S_UP_RD : S_WRITE;
          ACT_UPDATE: state_next = S_WRITE;
          ACT_DELETE: state_next = sts.del_shift ? S_DN_RD : S_FINISH;
          default:    state_next = S_FINISH;
        endcase
      end
      S_UP_RD: begin
        cmd.up_rd  = 1'b1;
        state_next = S_UP_WR;
      end
      S_UP_WR: begin
        cmd.up_wr  = 1'b1;
        state_next = sts.up_more ? S_UP_RD : S_WRITE;
      end
      S_DN_RD: begin
        cmd.dn_rd  = 1'b1;
        state_next = S_DN_WR;
      end
      S_DN_WR: begin
        cmd.dn_wr  = 1'b1;
        state_next = sts.dn_more ? S_DN_RD : S_FINISH;
      end
      S_WRITE: begin
        cmd.wr_new = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### src/sit_datapath.sv
// ----------------------------------------------------------------------------
// sit_datapath - storage, scan accumulators and result logic
// Holds the entry RAM, counters, per-word scan state and the response register.
// ----------------------------------------------------------------------------
module sit_datapath import sit_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_cmd_t             cmd,
  output ctl_sts_t             sts,
  input  cmd_word_t            in_word,
  input  logic                 cfg_we,
  input  logic [TIME_BITS-1:0] cfg_wdata,
  input  logic                 out_ready,
  output logic                 out_valid,
  output rsp_word_t            out_word
);

  cmd_word_t            req;
  logic [ID_W-1:0]      id_ctr;
  logic [ID_W-1:0]      id_nxt;
  logic [TIME_BITS-1:0] limit;
  logic [CNT_W-1:0]     count, count_new;
  logic [CNT_W-1:0]     j;
  logic [TIME_BITS-1:0] last_e;

  logic                 hit, hit_has_prev, want_next, nx_have;
  logic [CNT_W-1:0]     hit_idx;
  entry_t               hit_e;
  logic [TIME_BITS-1:0] hit_prev_e, nx_s;

  logic [CNT_W-1:0]     ins_p;
  logic                 ins_have_prev, ins_have_next;
  logic [TIME_BITS-1:0] ins_prev_e, ins_next_s;

  logic                 ga_found, gb_have, ch_on;
  logic [TIME_BITS-1:0] ga_s, gb_e, ch_e, ch_m;

  logic [CNT_W-1:0]     sh_i, wr_idx;
  act_t                 act_q;
  logic [STAT_W-1:0]    res_status;
  entry_t               res_entry;
  logic [TIME_BITS-1:0] res_measure;

  // RAM port signals
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [$bits(entry_t)-1:0] ram_wdata, ram_rdata;
  entry_t               rd;
  logic [TIME_BITS-1:0] t, rd_e;
  logic                 hit_cond;
  logic [CNT_W-1:0]     sh_dec, sh_inc;

  // decision outputs
  logic [STAT_W-1:0]    d_status;
  entry_t               d_entry;
  logic [TIME_BITS-1:0] d_measure;
  act_t                 d_act;
  logic [CNT_W-1:0]     d_wr;
  logic [TIME_BITS-1:0] room, trim1, gap_n, trim2, he;

  sit_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd     = entry_t'(ram_rdata);
  assign t      = req.at_time;
  assign rd_e   = rd.start + rd.length;
  assign sh_dec = sh_i - CNT_W'(1);
  assign sh_inc = sh_i + CNT_W'(1);

  // match of the current scanned entry for the request
  always_comb begin
    case (req.op)
      OP_SET_START, OP_SET_END, OP_DELETE, OP_READ_ID:
        hit_cond = (rd.id == req.entry_id);
      OP_FIND, OP_CHAIN:
        hit_cond = (rd.start <= t) && (t < rd_e);
      OP_READ_INDEX:
        hit_cond = ({{IX_W{1'b0}}, j} == {{CNT_W{1'b0}}, req.entry_index});
      default:
        hit_cond = 1'b0;
    endcase
  end

  // RAM addressing
  always_comb begin
    ram_raddr = j[IDX_W-1:0];
    if (cmd.up_rd) begin
      ram_raddr = sh_dec[IDX_W-1:0];
    end else if (cmd.dn_rd) begin
      ram_raddr = sh_inc[IDX_W-1:0];
    end
    ram_we    = cmd.up_wr | cmd.dn_wr | cmd.wr_new;
    ram_waddr = cmd.wr_new ? wr_idx[IDX_W-1:0] : sh_i[IDX_W-1:0];
    ram_wdata = cmd.wr_new ? res_entry : ram_rdata;
  end

  // next id, skipping the null id
  always_comb begin
    id_nxt = id_ctr + ID_W'(1);
    if (id_nxt == ID_NULL) begin
      id_nxt = ID_W'(1);
    end
  end

  // decide status, result word and table action
  always_comb begin
    room      = TIME_TOP - t;
    trim1     = (req.span_length > room) ? room : req.span_length;
    gap_n     = ins_next_s - t;
    trim2     = (ins_have_next && trim1 > gap_n) ? gap_n : trim1;
    he        = hit_e.start + hit_e.length;
    d_status  = ST_OK;
    d_entry   = '0;
    d_measure = '0;
    d_act     = ACT_NONE;
    d_wr      = hit_idx;
    case (req.op)
      OP_INSERT: begin
        if (trim2 == '0 || (ins_have_prev && ins_prev_e > t)) begin
          d_status = ST_REJECT;
        end else if ({1'b0, count} >= (CNT_W + 1)'(MAX_ENTRIES)) begin
          d_status = ST_FULL;
        end else begin
          d_act   = ACT_INSERT;
          d_wr    = ins_p;
          d_entry = '{id: id_ctr, colour: req.rgba_colour, start: t, length: trim2};
        end
      end
      OP_SET_START: begin
        if (!hit) begin
          d_status = ST_NO_ID;
        end else if (t >= he || (hit_has_prev && t < hit_prev_e)) begin
          d_status = ST_REJECT;
        end else begin
          d_act          = ACT_UPDATE;
          d_entry        = hit_e;
          d_entry.start  = t;
          d_entry.length = he - t;
        end
      end
      OP_SET_END: begin
        if (!hit) begin
          d_status = ST_NO_ID;
        end else if (t <= hit_e.start || (nx_have && t > nx_s)) begin
          d_status = ST_REJECT;
        end else begin
          d_act          = ACT_UPDATE;
          d_entry        = hit_e;
          d_entry.length = t - hit_e.start;
        end
      end
      OP_DELETE: begin
        if (!hit) begin
          d_status = ST_NO_ID;
        end else begin
          d_act   = ACT_DELETE;
          d_entry = hit_e;
        end
      end
      OP_FIND, OP_READ_INDEX: begin
        if (hit) d_entry = hit_e;
        else     d_status = ST_NONE;
      end
      OP_READ_ID: begin
        if (hit) d_entry = hit_e;
        else     d_status = ST_NO_ID;
      end
      OP_GAP_AHEAD: begin
        if (ga_found) d_measure = (ga_s > t) ? ga_s - t : '0;
        else          d_measure = (limit > t) ? limit - t : '0;
      end
      OP_GAP_BEHIND: begin
        if (gb_have) d_measure = (t > gb_e) ? t - gb_e : '0;
        else         d_measure = t;
      end
      OP_CHAIN: begin
        if (hit) d_measure = ch_m;
        else     d_status = ST_NONE;
      end
      OP_TOTAL: begin
        d_measure = (count != '0) ? last_e : '0;
      end
      default: d_status = ST_REJECT;
    endcase
  end

  // count after the operation
  always_comb begin
    case (act_q)
      ACT_INSERT: count_new = count + CNT_W'(1);
      ACT_DELETE: count_new = count - CNT_W'(1);
      default:    count_new = count;
    endcase
  end

  // status to the sequencer
  always_comb begin
    sts.cnt_zero  = (count == '0);
    sts.scan_last = ((j + CNT_W'(1)) == count);
    sts.act       = d_act;
    sts.ins_shift = (count > ins_p);
    sts.del_shift = ({1'b0, hit_idx} + (CNT_W + 1)'(1)) < {1'b0, count};
    sts.up_more   = (sh_dec > wr_idx);
    sts.dn_more   = ({1'b0, sh_i} + (CNT_W + 1)'(2)) < {1'b0, count};
    sts.out_free  = !out_valid || out_ready;
  end

  // control registers: count, id counter, limit, response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      id_ctr    <= ID_NULL;
      limit     <= TIME_TOP;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (cmd.start && in_word.op == OP_INSERT) begin
        id_ctr <= id_nxt;
      end
      if (cmd.finish) begin
        count     <= count_new;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // latch word, clear and advance the scan accumulators
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req           <= in_word;
      j             <= '0;
      hit           <= 1'b0;
      want_next     <= 1'b0;
      nx_have       <= 1'b0;
      ins_p         <= '0;
      ins_have_prev <= 1'b0;
      ins_have_next <= 1'b0;
      ga_found      <= 1'b0;
      gb_have       <= 1'b0;
      ch_on         <= 1'b0;
      ch_m          <= '0;
    end else if (cmd.scan_ev) begin
      j      <= j + CNT_W'(1);
      last_e <= rd_e;
      if (!hit && hit_cond) begin
        hit          <= 1'b1;
        hit_idx      <= j;
        hit_e        <= rd;
        hit_prev_e   <= last_e;
        hit_has_prev <= (j != '0);
        want_next    <= 1'b1;
        ch_on        <= 1'b1;
        ch_e         <= rd_e;
        ch_m         <= rd_e - t;
      end else begin
        if (want_next) begin
          want_next <= 1'b0;
          nx_have   <= 1'b1;
          nx_s      <= rd.start;
        end
        // extend an abutting chain
        if (ch_on) begin
          if (rd.start == ch_e) begin
            ch_m <= ch_m + rd.length;
            ch_e <= rd_e;
          end else begin
            ch_on <= 1'b0;
          end
        end
      end
      if (rd.start <= t) begin
        ins_p         <= j + CNT_W'(1);
        ins_have_prev <= 1'b1;
        ins_prev_e    <= rd_e;
      end else if (!ins_have_next) begin
        ins_have_next <= 1'b1;
        ins_next_s    <= rd.start;
      end
      if (!ga_found && rd_e > t) begin
        ga_found <= 1'b1;
        ga_s     <= rd.start;
      end
      if (rd.start < t) begin
        gb_have <= 1'b1;
        gb_e    <= rd_e;
      end
    end
  end

  // capture decision, walk the shift pointer
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_status  <= d_status;
      res_entry   <= d_entry;
      res_measure <= d_measure;
      act_q       <= d_act;
      wr_idx      <= d_wr;
      sh_i        <= (d_act == ACT_INSERT) ? count : hit_idx;
    end else if (cmd.up_wr) begin
      sh_i <= sh_dec;
    end else if (cmd.dn_wr) begin
      sh_i <= sh_inc;
    end
  end

  // load the response word
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word.status        <= res_status;
      out_word.result_id     <= res_entry.id;
      out_word.result_start  <= res_entry.start;
      out_word.result_length <= res_entry.length;
      out_word.result_colour <= res_entry.colour;
      out_word.measure       <= res_measure;
      out_word.entry_count   <= COUNT_W'(count_new);
    end
  end

endmodule

### src/sit_checker.sv
// ----------------------------------------------------------------------------
// sit_props - port-level checks of the interval table
// Response hold, count bound, zeroed fields on failure, command turnaround.
// ----------------------------------------------------------------------------
module sit_props import sit_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input rsp_word_t rsp_data
);

  // hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // count never exceeds the table size
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.entry_count <= COUNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  // failed operations carry no interval
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_OK |->
      rsp_data.result_id == '0 && rsp_data.result_length == '0 &&
      rsp_data.result_colour == '0)
    else $error("interval fields set on failed operation");

  // one command in work at a time
  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while busy");

endmodule

bind sorted_interval_table sit_props u_sit_props (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
